[rtl/core/ris_pkg.sv]
// shared types and constants of the recency ordered id set
package ris_pkg;

  // operation codes carried on kind
  typedef enum logic [1:0] {
    KIND_ADD       = 2'd0,
    KIND_REMOVE    = 2'd1,
    KIND_QUERY     = 2'd2,
    KIND_QUERY_ALT = 2'd3
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_DUP     = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_APPEND,
    S_RESP
  } state_e;

  // refresh distance after reset
  localparam logic [7:0] REFRESH_RESET = 8'd200;

  // commands from controller to datapath
  typedef struct packed {
    logic    latch;
    logic    scan_init;
    logic    shift_init;
    logic    shift_from_hit;
    logic    walk;
    logic    cnt_dec;
    logic    append;
    logic    set_result;
    status_e res_status;
    logic    res_present;
    logic    res_evicted;
    logic    res_refreshed;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic  id_zero;
    logic  walk_done;
    logic  hit;
    logic  full;
    logic  refresh_ok;
    kind_e kind;
  } sts_t;

endpackage

[rtl/core/recency_ordered_id_set_core.sv]
// top level of the recency ordered id set: controller, datapath and checks
//
// Keeps an ordered list of up to CAPACITY ids, oldest first, in one ram.
// A request (kind_i, user_id_i) is taken when start is high and busy is low:
// add appends an absent id (evicting the oldest when full), remove deletes
// an id and compacts the newer entries, query reports membership and moves
// the entry to the newest end when it lies more than refresh_distance
// places from the end. Each request gives one result, shown for exactly one
// cycle with done_o high; the receiver cannot stall it.
// Timing is set by the single ram port pair: a linear scan walks the
// stored entries, a compaction the entries newer than the removed or
// refreshed one (all on an eviction); accept, decision, append and result
// take a state each; a zero id goes from scan to result. The next request
// is taken the cycle after done_o. Reset empties the list (count to zero)
// and sets the distance to 200; ram contents are never read beyond the
// count. ready is always high. refresh_distance must be written over
// cfg_valid_i/cfg_ready_o only while idle; the block does not enforce it.
module recency_ordered_id_set_core #(
  parameter int CAPACITY = 128,
  parameter int ID_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [63:0] user_id_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic        present_o,
  output logic        evicted_o,
  output logic        refreshed_o,
  output logic [7:0]  count_after_o
);

  ris_pkg::cmd_t cmd;
  ris_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencer
  ris_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // storage and compare
  ris_dpath #(
    .CAPACITY (CAPACITY),
    .ID_WIDTH (ID_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (kind_i),
    .user_id_i     (user_id_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (status_o),
    .present_o     (present_o),
    .evicted_o     (evicted_o),
    .refreshed_o   (refreshed_o),
    .count_after_o (count_after_o)
  );

  // result strobe only while busy, and the block frees up right after it
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy ##1 !busy)
    else $error("result strobe outside a busy request");

  // an accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy && !done_o)
    else $error("accepted request did not start");

  // a rejected zero id carries no flags
  a_invalid_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ris_pkg::ST_INVALID) |->
      !present_o && !evicted_o && !refreshed_o)
    else $error("zero id result carries flags");

  // eviction and refresh only come with a completed operation
  a_flag_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (evicted_o || refreshed_o)) |->
      status_o == ris_pkg::ST_DONE && !(evicted_o && refreshed_o))
    else $error("eviction or refresh flag with wrong status");

endmodule

[rtl/core/ris_ram.sv]
// generic single write port ram with registered read
module ris_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ris_ctrl.sv]
// controller state machine of the recency ordered id set
module ris_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  input  ris_pkg::sts_t sts_i,
  output ris_pkg::cmd_t cmd_o
);

  ris_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ris_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ris_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.latch     = 1'b1;
          cmd_o.scan_init = 1'b1;
          state_d         = ris_pkg::S_SCAN;
        end
      end
      ris_pkg::S_SCAN: begin
        if (sts_i.id_zero) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = ris_pkg::ST_INVALID;
          state_d          = ris_pkg::S_RESP;
        end else if (sts_i.walk_done) begin
          state_d = ris_pkg::S_DECIDE;
        end else begin
          cmd_o.walk = 1'b1;
        end
      end
      ris_pkg::S_DECIDE: begin
        cmd_o.set_result  = 1'b1;
        cmd_o.res_present = sts_i.hit;
        unique case (sts_i.kind) inside
          ris_pkg::KIND_ADD: begin
            if (sts_i.hit) begin
              cmd_o.res_status = ris_pkg::ST_DUP;
              state_d          = ris_pkg::S_RESP;
            end else if (sts_i.full) begin
              // evict the oldest entry, then append
              cmd_o.res_status  = ris_pkg::ST_DONE;
              cmd_o.res_evicted = 1'b1;
              cmd_o.shift_init  = 1'b1;
              state_d           = ris_pkg::S_SHIFT;
            end else begin
              cmd_o.res_status = ris_pkg::ST_DONE;
              state_d          = ris_pkg::S_APPEND;
            end
          end
          ris_pkg::KIND_REMOVE: begin
            if (!sts_i.hit) begin
              cmd_o.res_status = ris_pkg::ST_ABSENT;
              state_d          = ris_pkg::S_RESP;
            end else begin
              cmd_o.res_status     = ris_pkg::ST_DONE;
              cmd_o.shift_init     = 1'b1;
              cmd_o.shift_from_hit = 1'b1;
              state_d              = ris_pkg::S_SHIFT;
            end
          end
          ris_pkg::KIND_QUERY, ris_pkg::KIND_QUERY_ALT: begin
            if (!sts_i.hit) begin
              cmd_o.res_status = ris_pkg::ST_ABSENT;
              state_d          = ris_pkg::S_RESP;
            end else if (sts_i.refresh_ok) begin
              // move the entry to the newest end
              cmd_o.res_status     = ris_pkg::ST_DONE;
              cmd_o.res_refreshed  = 1'b1;
              cmd_o.shift_init     = 1'b1;
              cmd_o.shift_from_hit = 1'b1;
              state_d              = ris_pkg::S_SHIFT;
            end else begin
              cmd_o.res_status = ris_pkg::ST_DONE;
              state_d          = ris_pkg::S_RESP;
            end
          end
          default: begin
            state_d = ris_pkg::S_RESP;
          end
        endcase
      end
      ris_pkg::S_SHIFT: begin
        if (sts_i.walk_done) begin
          cmd_o.cnt_dec = 1'b1;
          state_d = (sts_i.kind == ris_pkg::KIND_REMOVE) ? ris_pkg::S_RESP
                                                         : ris_pkg::S_APPEND;
        end else begin
          cmd_o.walk = 1'b1;
        end
      end
      ris_pkg::S_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = ris_pkg::S_RESP;
      end
      ris_pkg::S_RESP: begin
        done_o  = 1'b1;
        state_d = ris_pkg::S_IDLE;
      end
      default: begin
        state_d = ris_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/ris_dpath.sv]
// datapath: entry memory, walk pointer, count, compare and result registers
module ris_dpath #(
  parameter int CAPACITY = 128,
  parameter int ID_WIDTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    kind_i,
  input  logic [63:0]   user_id_i,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_data_i,
  input  ris_pkg::cmd_t cmd_i,
  output ris_pkg::sts_t sts_o,
  output logic [1:0]    status_o,
  output logic          present_o,
  output logic          evicted_o,
  output logic          refreshed_o,
  output logic [7:0]    count_after_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = (CW > 8) ? CW : 8;

  ris_pkg::kind_e   kind_q;
  ris_pkg::status_e status_q;
  logic [ID_WIDTH-1:0] id_q;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    pend_addr_q;
  logic [CW-1:0]    hit_idx_q;
  logic [CW-1:0]    shift_base;
  logic [CW-1:0]    shift_wa;
  logic [CW-1:0]    dist_span;
  logic [DW-1:0]    cnt_ext;
  logic [7:0]       dist_q;
  logic             pend_q;
  logic             mode_q;
  logic             hit_q;
  logic             present_q, evicted_q, refreshed_q;
  logic             issue;
  logic             match;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ID_WIDTH-1:0] ram_wdata;
  logic [ID_WIDTH-1:0] ram_rdata;

  // read issue while the walk pointer is below the count
  assign issue      = cmd_i.walk && (ptr_q < count_q);
  assign match      = pend_q && !mode_q && (ram_rdata == id_q);
  assign shift_base = cmd_i.shift_from_hit ? hit_idx_q : '0;
  assign shift_wa   = pend_addr_q - CW'(1);

  // memory write: shift moves an entry one slot down, append writes at the count
  assign ram_we    = (pend_q && mode_q) || cmd_i.append;
  assign ram_waddr = cmd_i.append ? count_q[AW-1:0] : shift_wa[AW-1:0];
  assign ram_wdata = cmd_i.append ? id_q : ram_rdata;

  ris_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // pointer and count next values
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.scan_init) begin
      ptr_d = '0;
    end else if (cmd_i.shift_init) begin
      ptr_d = shift_base + CW'(1);
    end else if (issue) begin
      ptr_d = ptr_q + CW'(1);
    end
    count_d = count_q;
    if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end else if (cmd_i.append) begin
      count_d = count_q + CW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
      mode_q  <= 1'b0;
      hit_q   <= 1'b0;
      dist_q  <= ris_pkg::REFRESH_RESET;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      pend_q  <= issue;
      if (cmd_i.scan_init) begin
        mode_q <= 1'b0;
        hit_q  <= 1'b0;
      end else if (cmd_i.shift_init) begin
        mode_q <= 1'b1;
      end else if (match) begin
        hit_q <= 1'b1;
      end
      if (cfg_we_i) begin
        dist_q <= cfg_data_i;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q <= ris_pkg::kind_e'(kind_i);
      id_q   <= user_id_i[ID_WIDTH-1:0];
    end
    if (issue) begin
      pend_addr_q <= ptr_q;
    end
    if (match) begin
      hit_idx_q <= pend_addr_q;
    end
    if (cmd_i.set_result) begin
      status_q    <= cmd_i.res_status;
      present_q   <= cmd_i.res_present;
      evicted_q   <= cmd_i.res_evicted;
      refreshed_q <= cmd_i.res_refreshed;
    end
  end

  // status towards the controller
  assign dist_span         = count_q - hit_idx_q;
  assign sts_o.id_zero     = (id_q == '0);
  assign sts_o.walk_done   = (ptr_q >= count_q) && !pend_q;
  assign sts_o.hit         = hit_q;
  assign sts_o.full        = (count_q == CW'(CAPACITY));
  assign sts_o.refresh_ok  = DW'(dist_span) > DW'(dist_q);
  assign sts_o.kind        = kind_q;

  // result outputs
  assign cnt_ext       = DW'(count_q);
  assign status_o      = status_q;
  assign present_o     = present_q;
  assign evicted_o     = evicted_q;
  assign refreshed_o   = refreshed_q;
  assign count_after_o = cnt_ext[7:0];

endmodule
